/* hw/rtl/nglu_pkg.sv */
// Shared types and codes for the nearest grid index lookup block.
// Holds the request and result structs, command, status and register codes.
// No dependencies.
`default_nettype none

package nglu_pkg;

  // Request: load a grid entry or query the nearest index.
  typedef struct packed {
    logic               command;
    logic [9:0]         entry_slot;
    logic signed [31:0] sample_value;
  } nglu_in_t;

  typedef struct packed {
    logic [10:0] nearest_index;
    logic [2:0]  lookup_status;
  } nglu_out_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [2:0] LS_FOUND    = 3'd0;
  localparam logic [2:0] LS_BELOW    = 3'd1;
  localparam logic [2:0] LS_ABOVE    = 3'd2;
  localparam logic [2:0] LS_EMPTY    = 3'd3;
  localparam logic [2:0] LS_UNSORTED = 3'd4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE_MODE = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } nglu_state_e;

  // Per-step qualifiers for the scan evaluator.
  typedef struct packed {
    logic run;
    logic first;
    logic scan_k;
    logic scan_d;
    logic check_order;
    logic last;
  } nglu_step_t;

endpackage

`default_nettype wire

/* hw/rtl/nearest_grid_index_lookup.sv */
// Nearest grid index lookup. The grid lives in a ring of TABLE_DEPTH cells;
// a load request writes one cell. A query request turns the ring once,
// presenting one entry per cycle to the evaluator, then resolves and
// registers its result. Loads are taken while a result waits at the output.
// Depends on nglu_pkg, nglu_cell and nglu_eval.
`default_nettype none

module nearest_grid_index_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [nglu_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [nglu_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  nglu_pkg::nglu_in_t                   in_req_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output nglu_pkg::nglu_out_t                  out_rsp_o
);
  import nglu_pkg::*;

  localparam int unsigned IW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned EXT = VALUE_WIDTH + 32;

  // Configuration registers.
  logic [10:0] entry_count_q;
  logic        inside_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      inside_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENTRY_COUNT: entry_count_q <= cfg_wdata_i[10:0];
        REG_INSIDE_MODE: inside_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Request value taken to VALUE_WIDTH bits as a signed quantity.
  logic [EXT-1:0]       raw_ext;
  logic signed [VW-1:0] req_val;
  assign raw_ext = {{VW{1'b0}}, in_req_i.sample_value};
  assign req_val = signed'(raw_ext[VW-1:0]);

  nglu_state_e state_q, state_d;
  logic [IW-1:0]        step_q, step_d;
  logic [CW-1:0]        n_q, n_d;
  logic signed [VW-1:0] x_q, x_d;
  logic                 out_valid_q, out_valid_d;
  nglu_out_t            out_q, out_d;
  nglu_out_t            result;
  logic                 in_fire, load_fire, shift;

  assign in_fire   = in_valid_i && in_ready_o;
  assign load_fire = in_fire && (in_req_i.command == CMD_LOAD);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    n_d         = n_q;
    x_d         = x_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    shift       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire && (in_req_i.command == CMD_QUERY)) begin
          x_d     = req_val;
          step_d  = '0;
          n_d     = (32'(entry_count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                       : CW'(entry_count_q);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift  = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == IW'(TABLE_DEPTH - 1)) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = result;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    n_q    <= n_d;
    x_q    <= x_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Ring of cells; cell 0 is the head seen by the evaluator.
  logic signed [VW-1:0] cell_val [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    nglu_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .load_i     (load_fire && (32'(in_req_i.entry_slot) == g)),
      .load_val_i (req_val),
      .next_val_i (cell_val[(g + 1) % TABLE_DEPTH]),
      .val_o      (cell_val[g])
    );
  end

  // Step qualifiers relative to the number of entries in use.
  nglu_step_t ctl;
  logic [31:0] s32, n32;

  always_comb begin
    s32             = 32'(step_q);
    n32             = 32'(n_q);
    ctl.run         = shift;
    ctl.first       = (s32 == 32'd0);
    ctl.scan_k      = (s32 >= 32'd1) && (s32 + 32'd2 <= n32);
    ctl.scan_d      = (s32 >= 32'd1) && (s32 < n32);
    ctl.check_order = (s32 + 32'd1 < n32);
    ctl.last        = (s32 + 32'd1 == n32);
  end

  nglu_eval #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .step_i   (step_q),
    .count_i  (n_q),
    .inside_i (inside_mode_q),
    .x_i      (x_q),
    .head_i   (cell_val[0]),
    .nxt_i    (cell_val[1]),
    .result_o (result)
  );

  a_query_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_req_i.command == CMD_QUERY)) |=> (state_q == ST_SCAN && step_q == '0))
    else $error("query request did not start a ring scan");

  a_no_request_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !in_ready_o)
    else $error("request accepted while the ring is turning");

  a_status_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_rsp_o.lookup_status == LS_FOUND) ==
                     (out_rsp_o.nearest_index != '0)))
    else $error("index and status disagree");

  a_scan_ends_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && step_q == IW'(TABLE_DEPTH - 1)) |=> (state_q == ST_RESOLVE))
    else $error("scan did not end after one full turn");

endmodule

`default_nettype wire

/* hw/rtl/nglu_cell.sv */
// One cell of the rotating grid ring: holds a single grid entry.
// Takes a load directly or the value of its neighbour when the ring turns.
// No dependencies.
`default_nettype none

module nglu_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          shift_i,
  input  wire                          load_i,
  input  wire signed [VALUE_WIDTH-1:0] load_val_i,
  input  wire signed [VALUE_WIDTH-1:0] next_val_i,
  output logic signed [VALUE_WIDTH-1:0] val_o
);

  logic signed [VALUE_WIDTH-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (load_i) begin
      val_q <= load_val_i;
    end else if (shift_i) begin
      val_q <= next_val_i;
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* hw/rtl/nglu_eval.sv */
// Scan evaluator: watches the ring head one entry per cycle and keeps the
// bracketing, nearest-distance and order summaries, then forms the result.
// Depends on nglu_pkg.
`default_nettype none

module nglu_eval #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  nglu_pkg::nglu_step_t                  ctl_i,
  input  wire [$clog2(TABLE_DEPTH)-1:0]         step_i,
  input  wire [$clog2(TABLE_DEPTH+1)-1:0]       count_i,
  input  wire                                   inside_i,
  input  wire signed [VALUE_WIDTH-1:0]          x_i,
  input  wire signed [VALUE_WIDTH-1:0]          head_i,
  input  wire signed [VALUE_WIDTH-1:0]          nxt_i,
  output nglu_pkg::nglu_out_t                   result_o
);
  import nglu_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned VW = VALUE_WIDTH;

  logic signed [VW-1:0] g0_q, glast_q, gk_q, gk1_q;
  logic [IW-1:0]        k_q, best_q;
  logic [VW:0]          d_q;
  logic                 sorted_q;

  logic signed [VW:0] diff;
  logic [VW:0]        dist_abs;
  logic               closer;
  logic               breaks;

  always_comb begin
    diff     = {x_i[VW-1], x_i} - {head_i[VW-1], head_i};
    dist_abs = diff[VW] ? (~diff + 1'b1) : diff;
    // Strictly nearer wins; an equal distance moves up unless entry 0 holds it.
    closer   = (dist_abs < d_q) || ((dist_abs == d_q) && (best_q != '0));
    breaks   = ctl_i.check_order && (nxt_i < head_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_q <= 1'b1;
    end else if (ctl_i.run) begin
      if (ctl_i.first) begin
        sorted_q <= !breaks;
      end else if (breaks) begin
        sorted_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.run) begin
      if (ctl_i.first) begin
        g0_q   <= head_i;
        gk_q   <= head_i;
        gk1_q  <= nxt_i;
        k_q    <= '0;
        d_q    <= dist_abs;
        best_q <= '0;
      end else begin
        if (ctl_i.scan_k && (head_i <= x_i)) begin
          gk_q  <= head_i;
          gk1_q <= nxt_i;
          k_q   <= step_i;
        end
        if (ctl_i.scan_d && closer) begin
          d_q    <= dist_abs;
          best_q <= step_i;
        end
      end
      if (ctl_i.last) begin
        glast_q <= head_i;
      end
    end
  end

  logic signed [VW:0] lo_gap, hi_gap;
  logic [31:0]        idx;

  always_comb begin
    lo_gap = {x_i[VW-1], x_i} - {gk_q[VW-1], gk_q};
    hi_gap = {gk1_q[VW-1], gk1_q} - {x_i[VW-1], x_i};
    idx    = 32'd0;
    result_o.lookup_status = LS_FOUND;
    if (count_i == '0) begin
      result_o.lookup_status = LS_EMPTY;
    end else if (sorted_q) begin
      if (x_i < g0_q) begin
        if (inside_i) result_o.lookup_status = LS_BELOW;
        else idx = 32'd1;
      end else if (x_i > glast_q) begin
        if (inside_i) result_o.lookup_status = LS_ABOVE;
        else idx = 32'(count_i);
      end else if (count_i == 1) begin
        idx = 32'd1;
      end else begin
        idx = 32'(k_q) + 32'd1 + ((lo_gap > hi_gap) ? 32'd1 : 32'd0);
      end
    end else if (inside_i) begin
      result_o.lookup_status = LS_UNSORTED;
    end else begin
      idx = 32'(best_q) + 32'd1;
    end
    result_o.nearest_index = idx[10:0];
  end

endmodule

`default_nettype wire
